@@ design/hilbert_numerator_reduce_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the Hilbert numerator reduce core
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef HILBERT_NUMERATOR_REDUCE_CORE_MACROS_SVH
`define HILBERT_NUMERATOR_REDUCE_CORE_MACROS_SVH

// generic clocked property
`define HNR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// same-cycle implication
`define HNR_ASSERT_IMP(label, ante, cons, msg) \
	`HNR_ASSERT(label, (ante) |-> (cons), msg)

// next-cycle implication
`define HNR_ASSERT_NXT(label, ante, cons, msg) \
	`HNR_ASSERT(label, (ante) |=> (cons), msg)

`endif

@@ design/hnr_pkg.sv @@
// ----------------------------------------------------------------------------
// hnr_pkg
// Shared widths, item and status codes and overflow-checked 48-bit add and subtract.
// ----------------------------------------------------------------------------
package hnr_pkg;

	// sizes
	localparam int COEFF_SLOTS_DEF = 64;
	localparam int VAL_W           = 48;
	localparam int BASE_W          = 11;
	localparam int IDX_W           = 6;
	localparam int COEF_W          = 32;
	localparam int KIND_W          = 2;
	localparam int STAT_W          = 3;
	localparam int CDEG_W          = 12;
	localparam int CDIM_W          = 7;
	localparam int POS_W           = 13;
	localparam int IN_DATA_W       = 56;
	localparam int OUT_DATA_W      = 168;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_START  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ADD    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REDUCE = 2'd2;
	localparam logic [KIND_W-1:0] KIND_READ   = 2'd3;

	// result status
	localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
	localparam logic [STAT_W-1:0] ST_DEG_LOW  = 3'd1;
	localparam logic [STAT_W-1:0] ST_CODIM    = 3'd2;
	localparam logic [STAT_W-1:0] ST_BOUND    = 3'd3;
	localparam logic [STAT_W-1:0] ST_NOTERM   = 3'd4;
	localparam logic [STAT_W-1:0] ST_OVERFLOW = 3'd5;

	typedef logic signed [VAL_W-1:0] val_t;

	typedef struct packed {
		logic ov;
		val_t sum;
	} sum_ov_t;

	// a + b, wrapped, with signed overflow flag
	function automatic sum_ov_t add_ov(input val_t a, input val_t b);
		sum_ov_t r;
		logic [VAL_W:0] s;
		s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
		r.ov = s[VAL_W] ^ s[VAL_W-1];
		r.sum = s[VAL_W-1:0];
		return r;
	endfunction

	// a - b, wrapped, with signed overflow flag
	function automatic sum_ov_t sub_ov(input val_t a, input val_t b);
		sum_ov_t r;
		logic [VAL_W:0] s;
		s = {a[VAL_W-1], a} - {b[VAL_W-1], b};
		r.ov = s[VAL_W] ^ s[VAL_W-1];
		r.sum = s[VAL_W-1:0];
		return r;
	endfunction

endpackage

@@ design/hnr_ram.sv @@
// ----------------------------------------------------------------------------
// hnr_ram
// Coefficient store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hnr_ram #(
	parameter int DEPTH = hnr_pkg::COEFF_SLOTS_DEF,
	parameter int WIDTH = hnr_pkg::VAL_W
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ design/hilbert_numerator_reduce_core.sv @@
// ----------------------------------------------------------------------------
// hilbert_numerator_reduce_core
// Keeps a Hilbert-series numerator of COEFF_SLOTS signed 48-bit coefficients
// in a single-port-write RAM, with start degree, codimension and coefficient
// sum in registers. One item is worked at a time; the input is not ready
// while an item is in progress. Add-term and read items go through request,
// RAM read and result; a refused add-term item goes from request straight
// to result; start clears the store with one RAM write per slot. Reduce
// works each division by (1-t) and the genus pass one slot at a time,
// because every slot goes through the one RAM read port. After reset the
// block runs a clearing pass over the store before it takes its first
// request. A finished result sits in an output register, so the next
// request is taken while it waits.
// ----------------------------------------------------------------------------
`include "hilbert_numerator_reduce_core_macros.svh"

module hilbert_numerator_reduce_core #(
	parameter int COEFF_SLOTS = hnr_pkg::COEFF_SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// base_degree, term_index, coefficient (from bit 0), zero pad
	input  logic [hnr_pkg::IN_DATA_W-1:0]    s_tdata,
	// kind
	input  logic [hnr_pkg::KIND_W-1:0]       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// status, coef_value, coef_degree, codimension, total_degree,
	// genus_value (from bit 0), zero pad
	output logic [hnr_pkg::OUT_DATA_W-1:0]   m_tdata
);

	localparam int IW = $clog2(COEFF_SLOTS);
	localparam int CW = $clog2(COEFF_SLOTS + 1);
	localparam int FW = CW + 1;
	localparam int PW = hnr_pkg::VAL_W + FW;
	localparam int GW = PW + 1;
	localparam int VW = hnr_pkg::VAL_W;
	localparam int SLOT_PAD = hnr_pkg::OUT_DATA_W - 166;

	// sequencer states
	localparam logic [3:0] S_CLEAR    = 4'd0;
	localparam logic [3:0] S_IDLE     = 4'd1;
	localparam logic [3:0] S_ADD      = 4'd2;
	localparam logic [3:0] S_READ     = 4'd3;
	localparam logic [3:0] S_RED_CHK  = 4'd4;
	localparam logic [3:0] S_DIV_RD   = 4'd5;
	localparam logic [3:0] S_DIV_CALC = 4'd6;
	localparam logic [3:0] S_DIV_END  = 4'd7;
	localparam logic [3:0] S_GEN_RD   = 4'd8;
	localparam logic [3:0] S_GEN_MUL  = 4'd9;
	localparam logic [3:0] S_GEN_END  = 4'd10;
	localparam logic [3:0] S_DONE     = 4'd11;

	// control state
	logic [3:0]                       state_q;
	logic [IW-1:0]                    ptr_q;
	logic                             clr_resp_q;
	logic signed [hnr_pkg::BASE_W-1:0] start_q;
	logic [CW-1:0]                    codim_q;
	hnr_pkg::val_t                    sum_q;
	logic                             pend_q;
	logic                             ov_q;
	logic                             m_tvalid_q;

	// payload registers
	logic [hnr_pkg::KIND_W-1:0]       kind_q;
	logic signed [hnr_pkg::COEF_W-1:0] coef_q;
	hnr_pkg::val_t                    prev_q;
	hnr_pkg::val_t                    g_q;
	logic signed [PW-1:0]             prod_q;
	logic [hnr_pkg::STAT_W-1:0]       res_status_q;
	hnr_pkg::val_t                    res_cval_q;
	logic [hnr_pkg::CDEG_W-1:0]       res_cdeg_q;
	logic                             rd_live_q;
	logic [hnr_pkg::OUT_DATA_W-1:0]   out_data_q;

	// request fields
	logic [hnr_pkg::KIND_W-1:0]        in_kind;
	logic signed [hnr_pkg::BASE_W-1:0] in_base;
	logic [hnr_pkg::IDX_W-1:0]         in_idx;
	logic signed [hnr_pkg::COEF_W-1:0] in_coef;
	logic                              accept;

	assign in_kind = s_tuser;
	assign in_base = s_tdata[10:0];
	assign in_idx  = s_tdata[16:11];
	assign in_coef = s_tdata[48:17];

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	// request decode: add position and read slot checks
	logic [hnr_pkg::POS_W-1:0] pos13;
	logic [hnr_pkg::POS_W-1:0] idx13;
	logic [hnr_pkg::POS_W-1:0] cdeg13;
	logic [hnr_pkg::POS_W-1:0] slots13;
	logic                      base_low;
	logic                      pos_out;
	logic                      idx_out;
	logic                      idx_live;

	assign idx13   = {{(hnr_pkg::POS_W - hnr_pkg::IDX_W){1'b0}}, in_idx};
	assign slots13 = hnr_pkg::POS_W'(COEFF_SLOTS);
	assign pos13   = {{2{in_base[10]}}, in_base} - {{2{start_q[10]}}, start_q} + idx13;
	assign base_low = in_base < start_q;
	assign pos_out  = pos13 >= slots13;
	assign idx_out  = idx13 >= slots13;
	assign idx_live = !idx_out && (idx13 >= hnr_pkg::POS_W'(codim_q));
	assign cdeg13   = idx13 + {{2{start_q[10]}}, start_q} - hnr_pkg::POS_W'(codim_q);

	// coefficient store
	logic          ram_we;
	logic [IW-1:0] ram_raddr;
	hnr_pkg::val_t ram_wdata;
	hnr_pkg::val_t ram_rdata;

	hnr_ram #(
		.DEPTH(COEFF_SLOTS),
		.WIDTH(hnr_pkg::VAL_W)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ptr_q),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// shared arithmetic
	hnr_pkg::val_t        coef_ext;
	hnr_pkg::sum_ov_t     st_add;
	hnr_pkg::sum_ov_t     div_sub;
	hnr_pkg::sum_ov_t     acc;
	hnr_pkg::val_t        acc_op;
	logic [FW-1:0]        fac_u;
	logic signed [FW-1:0] fac;
	logic signed [PW-1:0] prod;
	logic [GW-1:0]        gsum;
	logic                 gov;
	logic [CW-1:0]        ptr_ext;
	logic [CW+6:0]        cdim_ext;

	assign coef_ext = {{(VW - hnr_pkg::COEF_W){coef_q[hnr_pkg::COEF_W-1]}}, coef_q};
	assign st_add   = hnr_pkg::add_ov(ram_rdata, coef_ext);
	assign div_sub  = hnr_pkg::sub_ov(prev_q, ram_rdata);
	assign acc_op   = (state_q == S_ADD) ? coef_ext : prev_q;
	assign acc      = hnr_pkg::add_ov(sum_q, acc_op);

	assign ptr_ext = CW'(ptr_q);
	assign fac_u   = FW'(ptr_q) - FW'(codim_q) - FW'(1);
	assign fac     = fac_u;
	assign prod    = fac * ram_rdata;
	assign gsum    = {{(GW - VW){g_q[VW-1]}}, g_q} + {{(GW - PW){prod_q[PW-1]}}, prod_q};
	assign gov     = !((&gsum[GW-1:VW-1]) || !(|gsum[GW-1:VW-1]));
	assign cdim_ext = {7'd0, codim_q};

	// RAM port control
	always_comb begin
		ram_raddr = ptr_q;
		if (state_q == S_IDLE) begin
			ram_raddr = (in_kind == hnr_pkg::KIND_ADD) ? pos13[IW-1:0] : idx13[IW-1:0];
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = '0;
		case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
			end
			S_ADD: begin
				ram_we    = 1'b1;
				ram_wdata = st_add.sum;
			end
			S_DIV_CALC: begin
				ram_we    = 1'b1;
				ram_wdata = div_sub.sum;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// result assembly
	logic [hnr_pkg::STAT_W-1:0] red_status;
	logic [hnr_pkg::OUT_DATA_W-1:0] out_next;
	logic                           out_free;

	assign red_status = ov_q ? hnr_pkg::ST_OVERFLOW :
		((sum_q == '0) ? hnr_pkg::ST_NOTERM : hnr_pkg::ST_OK);
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		out_next = '0;
		unique case (kind_q)
			hnr_pkg::KIND_START, hnr_pkg::KIND_ADD: begin
				out_next[2:0] = res_status_q;
			end
			hnr_pkg::KIND_READ: begin
				out_next[2:0]   = res_status_q;
				out_next[50:3]  = res_cval_q;
				out_next[62:51] = res_cdeg_q;
			end
			hnr_pkg::KIND_REDUCE: begin
				out_next[2:0]     = red_status;
				out_next[69:63]   = cdim_ext[6:0];
				out_next[117:70]  = sum_q;
				out_next[165:118] = g_q;
			end
		endcase
		out_next[hnr_pkg::OUT_DATA_W-1 -: SLOT_PAD] = '0;
	end

	// sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			ptr_q      <= '0;
			clr_resp_q <= 1'b0;
			start_q    <= '0;
			codim_q    <= '0;
			sum_q      <= '0;
			pend_q     <= 1'b0;
			ov_q       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			// result taken, and no new one loads in this cycle
			if (m_tvalid_q && m_tready && (state_q != S_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					ptr_q <= ptr_q + IW'(1);
					if (ptr_q == IW'(COEFF_SLOTS - 1)) begin
						state_q <= clr_resp_q ? S_DONE : S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						unique case (in_kind)
							hnr_pkg::KIND_START: begin
								start_q    <= in_base;
								codim_q    <= '0;
								sum_q      <= '0;
								ptr_q      <= '0;
								clr_resp_q <= 1'b1;
								state_q    <= S_CLEAR;
							end
							hnr_pkg::KIND_ADD: begin
								ptr_q <= pos13[IW-1:0];
								if (base_low || (codim_q != '0) || pos_out) begin
									state_q <= S_DONE;
								end else begin
									state_q <= S_ADD;
								end
							end
							hnr_pkg::KIND_REDUCE: begin
								ov_q    <= 1'b0;
								pend_q  <= 1'b0;
								state_q <= S_RED_CHK;
							end
							hnr_pkg::KIND_READ: begin
								state_q <= S_READ;
							end
						endcase
					end
				end
				S_ADD: begin
					sum_q   <= acc.sum;
					state_q <= S_DONE;
				end
				S_READ: begin
					state_q <= S_DONE;
				end
				S_RED_CHK: begin
					pend_q <= 1'b0;
					if ((sum_q == '0) && (codim_q < CW'(COEFF_SLOTS))) begin
						ptr_q   <= IW'(COEFF_SLOTS - 1);
						state_q <= S_DIV_RD;
					end else if (codim_q == CW'(COEFF_SLOTS)) begin
						state_q <= S_DONE;
					end else begin
						ptr_q   <= codim_q[IW-1:0];
						state_q <= S_GEN_RD;
					end
				end
				S_DIV_RD: begin
					if (pend_q) begin
						sum_q <= acc.sum;
						ov_q  <= ov_q | acc.ov;
					end
					state_q <= S_DIV_CALC;
				end
				S_DIV_CALC: begin
					ov_q   <= ov_q | div_sub.ov;
					pend_q <= 1'b1;
					if (ptr_ext == codim_q) begin
						state_q <= S_DIV_END;
					end else begin
						ptr_q   <= ptr_q - IW'(1);
						state_q <= S_DIV_RD;
					end
				end
				S_DIV_END: begin
					sum_q   <= acc.sum;
					ov_q    <= ov_q | acc.ov;
					codim_q <= codim_q + CW'(1);
					pend_q  <= 1'b0;
					state_q <= S_RED_CHK;
				end
				S_GEN_RD: begin
					if (pend_q) begin
						ov_q <= ov_q | gov;
					end
					state_q <= S_GEN_MUL;
				end
				S_GEN_MUL: begin
					pend_q <= 1'b1;
					if (ptr_q == IW'(COEFF_SLOTS - 1)) begin
						state_q <= S_GEN_END;
					end else begin
						ptr_q   <= ptr_q + IW'(1);
						state_q <= S_GEN_RD;
					end
				end
				S_GEN_END: begin
					ov_q    <= ov_q | gov;
					pend_q  <= 1'b0;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						clr_resp_q <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// working values and result register
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					kind_q <= in_kind;
					coef_q <= in_coef;
					unique case (in_kind)
						hnr_pkg::KIND_START: begin
							res_status_q <= hnr_pkg::ST_OK;
						end
						hnr_pkg::KIND_ADD: begin
							priority if (base_low) begin
								res_status_q <= hnr_pkg::ST_DEG_LOW;
							end else if (codim_q != '0) begin
								res_status_q <= hnr_pkg::ST_CODIM;
							end else if (pos_out && (in_coef != '0)) begin
								res_status_q <= hnr_pkg::ST_BOUND;
							end else begin
								res_status_q <= hnr_pkg::ST_OK;
							end
						end
						hnr_pkg::KIND_REDUCE: begin
							res_status_q <= hnr_pkg::ST_OK;
						end
						hnr_pkg::KIND_READ: begin
							res_status_q <= idx_out ? hnr_pkg::ST_BOUND : hnr_pkg::ST_OK;
							rd_live_q    <= idx_live;
							res_cdeg_q   <= cdeg13[hnr_pkg::CDEG_W-1:0];
						end
					endcase
				end
			end
			S_ADD: begin
				res_status_q <= (st_add.ov || acc.ov) ? hnr_pkg::ST_OVERFLOW : hnr_pkg::ST_OK;
			end
			S_READ: begin
				res_cval_q <= rd_live_q ? ram_rdata : '0;
			end
			S_RED_CHK: begin
				prev_q <= '0;
				g_q    <= hnr_pkg::val_t'(1);
			end
			S_DIV_CALC: begin
				prev_q <= div_sub.sum;
			end
			S_GEN_RD: begin
				if (pend_q) begin
					g_q <= gsum[VW-1:0];
				end
			end
			S_GEN_MUL: begin
				prod_q <= prod;
			end
			S_GEN_END: begin
				g_q <= gsum[VW-1:0];
			end
			S_DONE: begin
				if (out_free) begin
					out_data_q <= out_next;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_data_q;

	// checks
	`HNR_ASSERT_IMP(a_codim_cap, 1'b1, codim_q <= CW'(COEFF_SLOTS), "codimension past slot count")
	`HNR_ASSERT_IMP(a_div_walk, state_q == S_DIV_CALC, ptr_ext >= codim_q, "division walked below codimension")
	`HNR_ASSERT_NXT(a_div_step, state_q == S_DIV_END, codim_q == $past(codim_q) + CW'(1), "codimension did not step")
	`HNR_ASSERT_IMP(a_result_src, $rose(m_tvalid_q), $past(state_q == S_DONE), "result loaded outside done")

endmodule
